[src/keyed_length_field_extractor_assert.svh]
// assertion macros for the keyed length field extractor
`ifndef KEYED_LENGTH_FIELD_EXTRACTOR_ASSERT_SVH
`define KEYED_LENGTH_FIELD_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define KLFE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("klfe assertion failed");

// next-cycle implication, disabled while in reset
`define KLFE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("klfe assertion failed");

`else

`define KLFE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define KLFE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

[src/klfe_pkg.sv]
package klfe_pkg;

	// length decoder sizing
	localparam int LENGTH_BITS = 35;
	localparam int GROUP_BITS  = 7;
	localparam int MAX_GROUPS  = (LENGTH_BITS + GROUP_BITS - 1) / GROUP_BITS;
	localparam int GROUP_W     = $clog2(MAX_GROUPS + 1);
	localparam int SHIFT_W     = $clog2(MAX_GROUPS * GROUP_BITS);
	localparam int EXT_W       = LENGTH_BITS + GROUP_BITS;

	// key prefix
	localparam int KEY_LEN   = 11;
	localparam int KEY_IDX_W = $clog2(KEY_LEN + 1);

	// length limit register
	localparam int             LIMIT_W     = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;
	localparam int CMP_W = (LENGTH_BITS > LIMIT_W) ? LENGTH_BITS : LIMIT_W;

	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		PH_MATCH,
		PH_VARINT,
		PH_EMIT,
		PH_SKIP
	} phase_t;

	// one result from the scan core
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              first;
		logic              last;
		logic              discard;
	} result_t;

	// key byte at a given prefix position
	function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] kb;
		unique case (idx)
			4'd0:    kb = 8'h0a;
			4'd1:    kb = 8'h08;
			4'd2:    kb = 8'h6c; // l
			4'd3:    kb = 8'h6f; // o
			4'd4:    kb = 8'h63; // c
			4'd5:    kb = 8'h61; // a
			4'd6:    kb = 8'h74; // t
			4'd7:    kb = 8'h69; // i
			4'd8:    kb = 8'h6f; // o
			4'd9:    kb = 8'h6e; // n
			4'd10:   kb = 8'h12;
			default: kb = 8'h00;
		endcase
		return kb;
	endfunction

endpackage

[src/keyed_length_field_extractor.sv]
// Keyed length field extractor.
// The input stream (s_*) carries one file byte per request, with s_tlast on
// the last byte of a file. The block looks for the key prefix 0x0a 0x08
// "location" 0x12, decodes the base-128 length that follows, and for a length
// from 1 to below length_limit forwards the value bytes on the output stream
// (m_*). m_tuser[0] marks the first value byte, m_tlast the last one, and
// m_tuser[1] marks a value cut off by the end of the file; drop it all.
// Other lengths are skipped with no output.
// Throughput is one byte per cycle. A result appears in the cycle after its byte
// is taken, from a single output register; the scan state updates in the same
// cycle the byte is taken. When the receiver stalls with a result held, s_tready
// drops until the register is taken; s_tready follows m_tready in that cycle.
// Reset clears the scan state and sets length_limit to 1024. cfg_we writes
// cfg_wdata to length_limit; write it only while no file is in progress.
// At the end of each file the scan state returns to its reset value.
module keyed_length_field_extractor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [klfe_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [klfe_pkg::BYTE_W-1:0]  s_tdata,  // data_byte
	input  logic                         s_tlast,  // end_of_file
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [klfe_pkg::BYTE_W-1:0]  m_tdata,  // value_byte
	output logic                         m_tlast,  // value_last
	output logic [1:0]                   m_tuser   // value_first, value_discard
);
	import klfe_pkg::*;

	`include "keyed_length_field_extractor_assert.svh"

	logic [LIMIT_W-1:0] length_limit_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_data_q;
	logic               out_first_q;
	logic               out_last_q;
	logic               out_discard_q;
	logic               step;
	result_t            res;

	// request handshake
	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	// length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			length_limit_q <= cfg_wdata;
		end
	end

	klfe_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (s_tdata),
		.end_of_file  (s_tlast),
		.length_limit (length_limit_q),
		.res          (res)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q    <= res.data;
			out_first_q   <= res.first;
			out_last_q    <= res.last;
			out_discard_q <= res.discard;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_discard_q, out_first_q};

	// checks
	`KLFE_ASSERT_NOW(a_discard_on_last, clk, arst_n, m_tvalid && m_tuser[1], m_tlast)
	`KLFE_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)
	`KLFE_ASSERT_NEXT(a_result_from_request, clk, arst_n, !step, !$rose(m_tvalid))

endmodule

[src/klfe_core.sv]
module klfe_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [klfe_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         end_of_file,
	input  logic [klfe_pkg::LIMIT_W-1:0] length_limit,
	output klfe_pkg::result_t            res
);
	import klfe_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [KEY_IDX_W-1:0]   prefix_q, prefix_d;
	logic [LENGTH_BITS-1:0] accum_q, accum_d;
	logic [GROUP_W-1:0]     group_q, group_d;
	logic [LENGTH_BITS-1:0] remain_q, remain_d;
	logic                   start_q, start_d;

	logic [SHIFT_W-1:0]     shift;
	logic [EXT_W-1:0]       group_ext;
	logic [LENGTH_BITS-1:0] accum_new;
	logic                   last_group;
	logic                   len_ok;
	logic [LENGTH_BITS-1:0] remain_dec;
	logic [KEY_IDX_W-1:0]   prefix_inc;

	// varint group placement and length checks
	assign shift      = SHIFT_W'(int'(group_q) * GROUP_BITS);
	assign group_ext  = EXT_W'(data_byte[GROUP_BITS-1:0]) << shift;
	assign accum_new  = accum_q | group_ext[LENGTH_BITS-1:0];
	assign last_group = (int'(shift) + GROUP_BITS) >= LENGTH_BITS;
	assign len_ok     = CMP_W'(accum_new) < CMP_W'(length_limit);
	assign remain_dec = remain_q - LENGTH_BITS'(1);

	// prefix match advance
	always_comb begin
		if ((int'(prefix_q) < KEY_LEN) && (data_byte == key_byte(prefix_q))) begin
			prefix_inc = prefix_q + KEY_IDX_W'(1);
		end else if (data_byte == key_byte('0)) begin
			prefix_inc = KEY_IDX_W'(1);
		end else begin
			prefix_inc = '0;
		end
	end

	// next state and result
	always_comb begin
		phase_d  = phase_q;
		prefix_d = prefix_q;
		accum_d  = accum_q;
		group_d  = group_q;
		remain_d = remain_q;
		start_d  = start_q;
		res      = '0;
		res.data = data_byte;
		unique case (phase_q)
			PH_VARINT: begin
				accum_d = accum_new;
				group_d = group_q + GROUP_W'(1);
				if (!data_byte[BYTE_W-1] || last_group) begin
					accum_d = '0;
					group_d = '0;
					if (accum_new == '0) begin
						phase_d = PH_MATCH;
					end else if (len_ok) begin
						phase_d  = PH_EMIT;
						remain_d = accum_new;
						start_d  = 1'b1;
					end else begin
						phase_d  = PH_SKIP;
						remain_d = accum_new;
					end
				end
			end
			PH_EMIT: begin
				remain_d    = remain_dec;
				res.valid   = 1'b1;
				res.first   = start_q;
				res.last    = (remain_dec == '0) || end_of_file;
				res.discard = end_of_file && (remain_dec != '0);
				start_d     = 1'b0;
				if (remain_dec == '0) begin
					phase_d = PH_MATCH;
				end
			end
			PH_SKIP: begin
				remain_d = remain_dec;
				if (remain_dec == '0) begin
					phase_d = PH_MATCH;
				end
			end
			default: begin
				prefix_d = prefix_inc;
				if (int'(prefix_inc) >= KEY_LEN) begin
					prefix_d = '0;
					phase_d  = PH_VARINT;
					accum_d  = '0;
					group_d  = '0;
				end
			end
		endcase
		// end of file returns the scan to its start
		if (end_of_file) begin
			phase_d  = PH_MATCH;
			prefix_d = '0;
			accum_d  = '0;
			group_d  = '0;
			remain_d = '0;
			start_d  = 1'b0;
		end
		res.valid = res.valid && step;
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MATCH;
			prefix_q <= '0;
			accum_q  <= '0;
			group_q  <= '0;
			remain_q <= '0;
			start_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			prefix_q <= prefix_d;
			accum_q  <= accum_d;
			group_q  <= group_d;
			remain_q <= remain_d;
			start_q  <= start_d;
		end
	end

endmodule

[tb/keyed_length_field_extractor_tb.sv]
module keyed_length_field_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import klfe_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int MAX_VARINT     = 5;

	// expected value stream and scan state of the extractor
	class value_scoreboard;
		typedef struct packed {
			logic [BYTE_W-1:0] data;
			logic              first;
			logic              last;
			logic              discard;
		} value_beat_t;

		value_beat_t            expected_beats[$];
		logic [BYTE_W-1:0]      key_seq[KEY_LEN];
		logic [LIMIT_W-1:0]     limit;
		phase_t                 scan_phase;
		int unsigned            key_pos;
		logic [LENGTH_BITS-1:0] accum;
		int unsigned            groups;
		logic [LENGTH_BITS-1:0] remaining;
		logic                   at_start;
		int                     mismatches;
		int                     checked;

		function new();
			// 0x0a 0x08 "location" 0x12
			key_seq = '{8'h0a, 8'h08, 8'h6c, 8'h6f, 8'h63, 8'h61, 8'h74, 8'h69, 8'h6f,
				8'h6e, 8'h12};
			limit = LIMIT_RESET;
			mismatches = 0;
			checked = 0;
			restart_scan();
		endfunction

		function void restart_scan();
			scan_phase = PH_MATCH;
			key_pos = 0;
			accum = '0;
			groups = 0;
			remaining = '0;
			at_start = 1'b0;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// advance the scan by one accepted file byte
		function void take_file_byte(logic [BYTE_W-1:0] b, logic eof);
			int unsigned shift;
			logic [LENGTH_BITS-1:0] len;
			value_beat_t beat;
			case (scan_phase)
				PH_VARINT: begin
					shift = groups * GROUP_BITS;
					accum = accum | (LENGTH_BITS'(b[6:0]) << shift);
					groups++;
					if (!b[7] || shift + GROUP_BITS >= LENGTH_BITS) begin
						len = accum;
						accum = '0;
						groups = 0;
						if (len == 0) begin
							scan_phase = PH_MATCH;
						end else if (len < LENGTH_BITS'(limit)) begin
							scan_phase = PH_EMIT;
							remaining = len;
							at_start = 1'b1;
						end else begin
							scan_phase = PH_SKIP;
							remaining = len;
						end
					end
				end
				PH_EMIT: begin
					remaining--;
					beat.data = b;
					beat.first = at_start;
					beat.last = (remaining == 0) || eof;
					beat.discard = eof && (remaining != 0);
					expected_beats.insert(expected_beats.size(), beat);
					at_start = 1'b0;
					if (remaining == 0) scan_phase = PH_MATCH;
				end
				PH_SKIP: begin
					remaining--;
					if (remaining == 0) scan_phase = PH_MATCH;
				end
				default: begin
					// a mismatching 0x0a restarts the key at its first byte
					if (key_pos < KEY_LEN && b == key_seq[key_pos]) key_pos++;
					else key_pos = (b == key_seq[0]) ? 1 : 0;
					if (key_pos >= KEY_LEN) begin
						key_pos = 0;
						scan_phase = PH_VARINT;
						accum = '0;
						groups = 0;
					end
				end
			endcase
			if (eof) restart_scan();
		endfunction

		// compare one output beat with the oldest expected one
		function void check_value_beat(logic [BYTE_W-1:0] data, logic first, logic last,
			logic discard);
			value_beat_t want;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected value byte %h first %b last %b discard %b",
						data, first, last, discard);
				return;
			end
			want = expected_beats.pop_front();
			checked++;
			if (want.data !== data || want.first !== first || want.last !== last ||
				want.discard !== discard) begin
				mismatches++;
				if (mismatches <= 10)
					$display("value byte mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
						want.data, want.first, want.last, want.discard,
						data, first, last, discard);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [LIMIT_W-1:0]   cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [BYTE_W-1:0]    s_tdata = '0;   // data_byte
	logic                 s_tlast = 1'b0; // end_of_file
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [BYTE_W-1:0]    m_tdata;        // value_byte
	logic                 m_tlast;        // value_last
	logic [1:0]           m_tuser;        // value_first, value_discard

	value_scoreboard      sb = new();
	logic [BYTE_W-1:0]    file_q[$];
	bit                   no_idle = 1'b0;
	bit                   hold_output = 1'b0;
	int                   holds_done = 0;
	int                   bytes_sent = 0;
	int                   files_sent = 0;
	int                   limit_writes = 0;

	keyed_length_field_extractor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// accepted requests on both sides
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.take_file_byte(s_tdata, s_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_value_beat(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
				holds_done++;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 32);
			end
		end
	end

	// watchdog on cycles with no request taken on either side
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("timeout: no request taken for %0d cycles", WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	// one file byte, with random idle cycles ahead of it unless no_idle is set
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eof);
		if (!no_idle) begin
			while ($urandom_range(99) < 32) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eof;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++) begin
			send_byte(file_q[i], i == file_q.size() - 1);
			bytes_sent++;
		end
		file_q.delete();
		files_sent++;
	endtask

	// stop offering and wait until every expected value byte is out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.limit = value;
		limit_writes++;
	endtask

	task automatic push_key(input int count);
		for (int i = 0; i < count; i++) file_q.insert(file_q.size(), sb.key_seq[i]);
	endtask

	// base-128 length; pad adds redundant groups, overrun keeps the
	// continuation bit on through the last allowed group
	task automatic push_varint(input logic [LENGTH_BITS-1:0] len, input int pad,
		input bit overrun);
		int n;
		int total;
		logic [BYTE_W-1:0] grp;
		n = 1;
		while (n < MAX_VARINT && (len >> (GROUP_BITS * n)) != 0) n++;
		total = overrun ? MAX_VARINT : ((n + pad > MAX_VARINT) ? MAX_VARINT : n + pad);
		for (int i = 0; i < total; i++) begin
			grp = BYTE_W'((len >> (GROUP_BITS * i)) & 35'h7f);
			if (i < total - 1 || overrun) grp[7] = 1'b1;
			file_q.insert(file_q.size(), grp);
		end
	endtask

	task automatic push_random(input int count);
		repeat (count) file_q.insert(file_q.size(), BYTE_W'($urandom));
	endtask

	// filler biased toward key bytes so partial keys show up
	task automatic push_noise();
		if ($urandom_range(3) == 0)
			file_q.insert(file_q.size(), sb.key_seq[$urandom_range(KEY_LEN - 1)]);
		else file_q.insert(file_q.size(), BYTE_W'($urandom));
	endtask

	function automatic logic [LENGTH_BITS-1:0] pick_length(input logic [LIMIT_W-1:0] lim);
		int r;
		r = $urandom_range(99);
		if (r < 55 && lim >= 2)
			return LENGTH_BITS'($urandom_range(1, (lim > 13) ? 12 : int'(lim) - 1));
		if (r < 65) return (lim == 0) ? LENGTH_BITS'($urandom_range(1, 4)) : LENGTH_BITS'(lim);
		if (r < 72) return '0;
		if (r < 80 && lim >= 2) return LENGTH_BITS'(lim - 1);
		if (r < 90) return LENGTH_BITS'($urandom_range(1, 12));
		return LENGTH_BITS'({$urandom, $urandom});
	endfunction

	// mostly keyed records with random content, some noise and broken files
	task automatic send_random_file(input logic [LIMIT_W-1:0] lim);
		int records;
		int nbytes;
		bit cut;
		logic [LENGTH_BITS-1:0] len;
		cut = 1'b0;
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 8)) push_noise();
		end else begin
			records = $urandom_range(1, 3);
			for (int i = 0; i < records && !cut; i++) begin
				repeat ($urandom_range(0, 3)) push_noise();
				if ($urandom_range(99) < 20) push_key($urandom_range(1, KEY_LEN - 1));
				push_key(KEY_LEN);
				if ($urandom_range(99) < 5) begin
					// file ends inside the length
					file_q.insert(file_q.size(), 8'h80 | BYTE_W'($urandom_range(127)));
					cut = 1'b1;
				end else begin
					len = pick_length(lim);
					if ($urandom_range(99) < 5 && len < 128) push_varint(len, 0, 1'b1);
					else push_varint(len, ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0,
						1'b0);
					if (len > 24) begin
						nbytes = $urandom_range(0, 24);
						cut = 1'b1;
					end else if (len != 0 && $urandom_range(99) < 10) begin
						nbytes = $urandom_range(0, int'(len) - 1);
						cut = 1'b1;
					end else begin
						nbytes = int'(len);
					end
					push_random(nbytes);
				end
			end
			if (!cut) repeat ($urandom_range(0, 2)) push_noise();
		end
		send_file();
	endtask

	task automatic run_random_phase(input logic [LIMIT_W-1:0] lim, input int target);
		int start;
		write_limit(lim);
		start = bytes_sent;
		while (bytes_sent - start < target) send_random_file(lim);
	endtask

	initial begin
		logic [LIMIT_W-1:0] phase_limits[8];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: value that ends exactly with the file
		push_key(KEY_LEN);
		push_varint(3, 0, 1'b0);
		file_q.insert(file_q.size(), 8'h00);
		file_q.insert(file_q.size(), 8'hff);
		file_q.insert(file_q.size(), 8'h5a);
		send_file();
		// restart on a stray 0x0a, zero length, one-byte value, trailing junk
		push_key(3);
		push_key(KEY_LEN);
		push_varint(0, 0, 1'b0);
		push_key(KEY_LEN);
		push_varint(1, 0, 1'b0);
		file_q.insert(file_q.size(), 8'h80);
		file_q.insert(file_q.size(), 8'h33);
		send_file();
		// length still continuing after the last group, then a skip cut by eof
		push_key(KEY_LEN);
		push_varint(3, 0, 1'b1);
		push_random(3);
		push_key(KEY_LEN);
		push_varint(1024, 0, 1'b0);
		push_random(4);
		send_file();
		// value cut off after two bytes, and on its first byte
		push_key(KEY_LEN);
		push_varint(5, 0, 1'b0);
		push_random(2);
		send_file();
		push_key(KEY_LEN);
		push_varint(2, 0, 1'b0);
		push_random(1);
		send_file();
		// file ends inside the key and inside the length
		push_key(6);
		send_file();
		push_key(KEY_LEN);
		file_q.insert(file_q.size(), 8'h81);
		send_file();
		// largest length, skipped; the overrun record after it lies inside the skip
		push_key(KEY_LEN);
		push_varint('1, 0, 1'b0);
		push_random(2);
		push_key(KEY_LEN);
		push_varint('1, 0, 1'b1);
		push_random(3);
		send_file();
		// just under the limit, padded encoding, cut off
		push_key(KEY_LEN);
		push_varint(1023, 2, 1'b0);
		push_random(2);
		send_file();

		// limits that reject every length
		write_limit('0);
		push_key(KEY_LEN);
		push_varint(1, 0, 1'b0);
		push_random(1);
		push_key(KEY_LEN);
		push_varint(2, 0, 1'b0);
		push_random(2);
		send_file();
		write_limit(1);
		push_key(KEY_LEN);
		push_varint(1, 0, 1'b0);
		push_random(1);
		push_key(KEY_LEN);
		push_varint(2, 0, 1'b0);
		push_random(2);
		send_file();

		// widest limit
		write_limit('1);
		push_key(KEY_LEN);
		push_varint(65534, 0, 1'b0);
		push_random(3);
		send_file();
		push_key(KEY_LEN);
		push_varint(65535, 0, 1'b0);
		push_random(2);
		send_file();
		push_key(KEY_LEN);
		push_varint(4, 0, 1'b0);
		push_random(4);
		send_file();

		// small limit: accepted and skipped at the boundary
		write_limit(4);
		push_key(KEY_LEN);
		push_varint(3, 0, 1'b0);
		push_random(3);
		push_key(KEY_LEN);
		push_varint(4, 0, 1'b0);
		push_random(4);
		push_key(KEY_LEN);
		push_varint(3, 0, 1'b0);
		push_random(3);
		send_file();

		// random files under a range of limits
		phase_limits = '{16'd5, 16'd1024, 16'd0, 16'd65535, 16'd1, 16'd17,
			16'($urandom_range(2, 40)), 16'($urandom)};
		for (int p = 0; p < 8; p++) begin
			if (p == 1) hold_output = 1'b1;
			no_idle = (p == 5);
			run_random_phase(phase_limits[p], 20);
		end
		no_idle = 1'b0;
		drain();

		$display("covered %0d file bytes in %0d files under %0d length limit settings",
			bytes_sent, files_sent, limit_writes);
		$display("checked %0d value bytes, %0d output hold-off(s)", sb.checked, holds_done);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d value bytes missing", sb.mismatches, sb.pending());
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/klfe_pkg.sv
src/klfe_core.sv
src/keyed_length_field_extractor.sv
tb/keyed_length_field_extractor_tb.sv
